### rtl/core/usb_host_controller_registers_defines.svh
// Assertion macros for the host controller register file.
`ifndef USB_HOST_CONTROLLER_REGISTERS_DEFINES_SVH
`define USB_HOST_CONTROLLER_REGISTERS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UHCR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define UHCR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/uhcr_pkg.sv
// Types and constants of the host controller register file.
`timescale 1ns / 1ps

package uhcr_pkg;

   localparam int PORT_COUNT = 2;
   localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int LIST_COUNT = 6;
   localparam int PORT_W     = 21;

   // Request kinds
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_DEVICE = 2'd3;

   // Register offsets
   localparam logic [7:0] ADDR_REVISION  = 8'h00;
   localparam logic [7:0] ADDR_CONTROL   = 8'h04;
   localparam logic [7:0] ADDR_COMMAND   = 8'h08;
   localparam logic [7:0] ADDR_INT_STAT  = 8'h0c;
   localparam logic [7:0] ADDR_INT_SET   = 8'h10;
   localparam logic [7:0] ADDR_INT_CLR   = 8'h14;
   localparam logic [7:0] ADDR_HCCA      = 8'h18;
   localparam logic [7:0] ADDR_LIST0     = 8'h1c;
   localparam logic [7:0] ADDR_LIST1     = 8'h20;
   localparam logic [7:0] ADDR_LIST2     = 8'h24;
   localparam logic [7:0] ADDR_LIST3     = 8'h28;
   localparam logic [7:0] ADDR_LIST4     = 8'h2c;
   localparam logic [7:0] ADDR_LIST5     = 8'h30;
   localparam logic [7:0] ADDR_FM_INTVL  = 8'h34;
   localparam logic [7:0] ADDR_FM_REMAIN = 8'h38;
   localparam logic [7:0] ADDR_FM_NUMBER = 8'h3c;
   localparam logic [7:0] ADDR_PER_START = 8'h40;
   localparam logic [7:0] ADDR_LS_THRESH = 8'h44;
   localparam logic [7:0] ADDR_RH_DESC_A = 8'h48;
   localparam logic [7:0] ADDR_RH_DESC_B = 8'h4c;
   localparam logic [7:0] ADDR_RH_STATUS = 8'h50;
   localparam logic [5:0] PORT_WORD_BASE = 6'h15;  // offset 0x54 in words

   localparam logic [31:0] REVISION_VALUE = 32'h0000_0010;
   localparam logic [31:0] INT_SF         = 32'h0000_0004;
   localparam logic [31:0] INT_RHSC       = 32'h0000_0040;
   localparam logic [31:0] INT_OC         = 32'h4000_0000;
   localparam logic [31:0] INT_ENABLE_BITS = 32'h7fff_ffff;
   localparam logic [31:0] HCCA_MASK      = 32'hffff_ff00;
   localparam logic [31:0] LIST_MASK      = 32'hffff_fff0;
   localparam logic [31:0] CONTROL_SUSP   = 32'h0000_00c0;
   localparam logic [1:0]  HCFS_OPER      = 2'b10;
   localparam logic [31:0] FM_INTVL_RESET = 32'h0000_2edf;
   localparam logic [31:0] LS_THRESH_RESET = 32'h0000_0628;
   localparam logic [31:0] DESC_A_FIXED   = 32'h0100_0200;
   localparam logic [3:0]  COMMAND_MASK   = 4'he;

   // Port status bits
   localparam logic [PORT_W-1:0] PS_CCS  = 21'h000001;
   localparam logic [PORT_W-1:0] PS_PES  = 21'h000002;
   localparam logic [PORT_W-1:0] PS_PSS  = 21'h000004;
   localparam logic [PORT_W-1:0] PS_PRS  = 21'h000010;
   localparam logic [PORT_W-1:0] PS_PPS  = 21'h000100;
   localparam logic [PORT_W-1:0] PS_CSC  = 21'h010000;
   localparam logic [PORT_W-1:0] PS_PRSC = 21'h100000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  addr;
      logic [31:0] wdata;
      logic        port;
      logic        device_present;
   } req_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        irq_raise;
      logic        port_reset_req;
      logic        reset_port;
   } rsp_type;

   typedef struct packed {
      logic irq_level;
      logic rhsc;
   } status_type;

endpackage

### rtl/core/uhcr_req_stage.sv
// Input register of the host controller register file.
`timescale 1ns / 1ps

module uhcr_req_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  uhcr_pkg::req_type req_in,
   input  logic              advance,
   output logic              valid_ff,
   output uhcr_pkg::req_type req_ff
);
   import uhcr_pkg::*;

   logic accept;
   logic valid_in;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

endmodule

### rtl/core/uhcr_core.sv
// Register state and request decode of the host controller register file.
`timescale 1ns / 1ps

module uhcr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  uhcr_pkg::req_type    req,
   output uhcr_pkg::rsp_type    rsp_in,
   output uhcr_pkg::status_type status
);
   import uhcr_pkg::*;

   typedef struct packed {
      logic [PORT_W-1:0] state;
      logic              did_reset;
   } port_wr_type;

   function automatic port_wr_type port_write(input logic [PORT_W-1:0] s_in,
                                              input logic [31:0] v);
      port_wr_type r;
      logic [PORT_W-1:0] s;
      s = s_in;
      r.did_reset = 1'b0;
      if (v[0]) s = s & ~PS_PES;
      if (v[1] && s[0]) s = s | PS_PES;
      if (v[2] && s[0]) s = s | PS_PSS;
      if (v[3]) s = s & ~PS_PSS;
      if (v[4] && s[0]) begin
         s = (s & ~PS_PRS) | PS_PES | PS_PRSC;
         r.did_reset = 1'b1;
      end
      if (v[8]) s = s | PS_PPS;
      if (v[9]) s = s & ~PS_PPS;
      // change bits are write-1-to-clear
      s[20:16] = s[20:16] & ~v[20:16];
      r.state = s;
      return r;
   endfunction

   logic [31:0]       control_ff, control_in;
   logic [3:0]        command_ff, command_in;
   logic [31:0]       int_stat_ff, int_stat_in;
   logic [31:0]       int_en_ff, int_en_in;
   logic [31:0]       hcca_ff, hcca_in;
   logic [31:0]       list_ff [LIST_COUNT];
   logic [31:0]       list_in [LIST_COUNT];
   logic [31:0]       fm_intvl_ff, fm_intvl_in;
   logic [13:0]       fm_remain_ff, fm_remain_in;
   logic [15:0]       fm_number_ff, fm_number_in;
   logic [31:0]       per_start_ff, per_start_in;
   logic [31:0]       ls_thresh_ff, ls_thresh_in;
   logic [31:0]       desc_a_ff, desc_a_in;
   logic [31:0]       desc_b_ff, desc_b_in;
   logic              lpsc_ff, lpsc_in;
   logic [PORT_W-1:0] port_ff [PORT_COUNT];
   logic [PORT_W-1:0] port_in [PORT_COUNT];
   logic              port_change_any;
   port_wr_type       pw;

   always_comb begin
      port_change_any = 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
         port_change_any = port_change_any | (|port_ff[i][20:16]);
      end
   end

   assign status.irq_level = int_en_ff[31] && (|(int_stat_ff & int_en_ff & INT_ENABLE_BITS));
   assign status.rhsc      = |(int_stat_ff & INT_RHSC);

   always_comb begin
      control_in   = control_ff;
      command_in   = command_ff;
      int_stat_in  = int_stat_ff;
      int_en_in    = int_en_ff;
      hcca_in      = hcca_ff;
      list_in      = list_ff;
      fm_intvl_in  = fm_intvl_ff;
      fm_remain_in = fm_remain_ff;
      fm_number_in = fm_number_ff;
      per_start_in = per_start_ff;
      ls_thresh_in = ls_thresh_ff;
      desc_a_in    = desc_a_ff;
      desc_b_in    = desc_b_ff;
      lpsc_in      = lpsc_ff;
      port_in      = port_ff;
      rsp_in       = '0;
      pw           = '0;

      case (req.kind)
         KIND_READ: begin
            case (req.addr)
               ADDR_REVISION:  rsp_in.rdata = REVISION_VALUE;
               ADDR_CONTROL:   rsp_in.rdata = control_ff;
               ADDR_COMMAND:   rsp_in.rdata = {28'b0, command_ff};
               ADDR_INT_STAT:  rsp_in.rdata = int_stat_ff;
               ADDR_INT_SET:   rsp_in.rdata = int_en_ff;
               ADDR_INT_CLR:   rsp_in.rdata = int_en_ff;
               ADDR_HCCA:      rsp_in.rdata = hcca_ff;
               ADDR_LIST0:     rsp_in.rdata = list_ff[0];
               ADDR_LIST1:     rsp_in.rdata = list_ff[1];
               ADDR_LIST2:     rsp_in.rdata = list_ff[2];
               ADDR_LIST3:     rsp_in.rdata = list_ff[3];
               ADDR_LIST4:     rsp_in.rdata = list_ff[4];
               ADDR_LIST5:     rsp_in.rdata = list_ff[5];
               ADDR_FM_INTVL:  rsp_in.rdata = fm_intvl_ff;
               ADDR_FM_REMAIN: rsp_in.rdata = {18'b0, fm_remain_ff};
               ADDR_FM_NUMBER: rsp_in.rdata = {16'b0, fm_number_ff};
               ADDR_PER_START: rsp_in.rdata = per_start_ff;
               ADDR_LS_THRESH: rsp_in.rdata = ls_thresh_ff;
               ADDR_RH_DESC_A: rsp_in.rdata = desc_a_ff;
               ADDR_RH_DESC_B: rsp_in.rdata = desc_b_ff;
               ADDR_RH_STATUS: rsp_in.rdata = {16'b0, lpsc_ff, 15'b0};
               default: begin
                  for (int i = 0; i < PORT_COUNT; i++) begin
                     if (req.addr[7:2] == 6'(PORT_WORD_BASE + 6'(i))) begin
                        rsp_in.rdata = {{(32 - PORT_W){1'b0}}, port_ff[i]};
                     end
                  end
               end
            endcase
         end

         KIND_WRITE: begin
            case (req.addr)
               ADDR_CONTROL: begin
                  control_in = req.wdata;
                  if (req.wdata[7:6] != control_ff[7:6] && req.wdata[7:6] == HCFS_OPER
                      && port_change_any) begin
                     int_stat_in = int_stat_in | INT_RHSC;
                  end
               end
               ADDR_COMMAND: begin
                  // soft reset first, then the list-filled and ownership bits
                  if (req.wdata[0]) begin
                     control_in   = CONTROL_SUSP;
                     command_in   = '0;
                     int_stat_in  = '0;
                     int_en_in    = '0;
                     hcca_in      = '0;
                     fm_remain_in = '0;
                     for (int i = 0; i < LIST_COUNT; i++) begin
                        list_in[i] = '0;
                     end
                  end
                  command_in = command_in | (req.wdata[3:0] & COMMAND_MASK);
                  if (req.wdata[3]) int_stat_in = int_stat_in | INT_OC;
               end
               ADDR_INT_STAT:  int_stat_in = int_stat_ff & ~req.wdata;
               ADDR_INT_SET:   int_en_in = int_en_ff | req.wdata;
               ADDR_INT_CLR:   int_en_in = int_en_ff & ~req.wdata;
               ADDR_HCCA:      hcca_in = req.wdata & HCCA_MASK;
               ADDR_LIST0:     list_in[0] = req.wdata & LIST_MASK;
               ADDR_LIST1:     list_in[1] = req.wdata & LIST_MASK;
               ADDR_LIST2:     list_in[2] = req.wdata & LIST_MASK;
               ADDR_LIST3:     list_in[3] = req.wdata & LIST_MASK;
               ADDR_LIST4:     list_in[4] = req.wdata & LIST_MASK;
               ADDR_LIST5:     list_in[5] = req.wdata;
               ADDR_FM_INTVL:  fm_intvl_in = req.wdata;
               ADDR_PER_START: per_start_in = req.wdata;
               ADDR_LS_THRESH: ls_thresh_in = req.wdata;
               ADDR_RH_DESC_A: desc_a_in = (req.wdata & HCCA_MASK) | 32'(PORT_COUNT);
               ADDR_RH_DESC_B: desc_b_in = req.wdata;
               ADDR_RH_STATUS: begin
                  for (int i = 0; i < PORT_COUNT; i++) begin
                     if (req.wdata[16]) port_in[i] = port_in[i] | PS_PPS;
                     if (req.wdata[0]) port_in[i] = port_in[i] & ~PS_PPS;
                  end
                  if (req.wdata[15]) lpsc_in = 1'b1;
                  if (req.wdata[31]) lpsc_in = 1'b0;
               end
               default: begin
                  for (int i = 0; i < PORT_COUNT; i++) begin
                     if (req.addr[7:2] == 6'(PORT_WORD_BASE + 6'(i))) begin
                        pw = port_write(port_ff[i], req.wdata);
                        port_in[i] = pw.state;
                        if (pw.did_reset) begin
                           int_stat_in           = int_stat_in | INT_RHSC;
                           rsp_in.port_reset_req = 1'b1;
                           rsp_in.reset_port     = i[0];
                        end
                     end
                  end
               end
            endcase
         end

         KIND_TICK: begin
            if (control_ff[7:6] == HCFS_OPER) begin
               fm_number_in = fm_number_ff + 16'd1;
               fm_remain_in = fm_intvl_ff[13:0];
               int_stat_in  = int_stat_ff | INT_SF;
               if (control_ff[4]) command_in[1] = 1'b0;
               if (control_ff[5]) command_in[2] = 1'b0;
            end
         end

         KIND_DEVICE: begin
            for (int i = 0; i < PORT_COUNT; i++) begin
               if (32'(req.port) == i) begin
                  port_in[i] = req.device_present ? (PS_CCS | PS_PPS | PS_CSC)
                                                  : (PS_PPS | PS_CSC);
                  int_stat_in = int_stat_ff | INT_RHSC;
               end
            end
         end

         default: ;
      endcase

      rsp_in.irq_raise = int_en_in[31] && (|(int_stat_in & int_en_in & INT_ENABLE_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= '0;
         command_ff   <= '0;
         int_stat_ff  <= '0;
         int_en_ff    <= '0;
         hcca_ff      <= '0;
         fm_intvl_ff  <= FM_INTVL_RESET;
         fm_remain_ff <= '0;
         fm_number_ff <= '0;
         per_start_ff <= '0;
         ls_thresh_ff <= LS_THRESH_RESET;
         desc_a_ff    <= DESC_A_FIXED | 32'(PORT_COUNT);
         desc_b_ff    <= '0;
         lpsc_ff      <= 1'b0;
         for (int i = 0; i < LIST_COUNT; i++) begin
            list_ff[i] <= '0;
         end
         for (int i = 0; i < PORT_COUNT; i++) begin
            port_ff[i] <= (i == 0) ? (PS_CCS | PS_PPS | PS_CSC) : (PS_PPS | PS_CSC);
         end
      end else if (advance) begin
         control_ff   <= control_in;
         command_ff   <= command_in;
         int_stat_ff  <= int_stat_in;
         int_en_ff    <= int_en_in;
         hcca_ff      <= hcca_in;
         fm_intvl_ff  <= fm_intvl_in;
         fm_remain_ff <= fm_remain_in;
         fm_number_ff <= fm_number_in;
         per_start_ff <= per_start_in;
         ls_thresh_ff <= ls_thresh_in;
         desc_a_ff    <= desc_a_in;
         desc_b_ff    <= desc_b_in;
         lpsc_ff      <= lpsc_in;
         list_ff      <= list_in;
         port_ff      <= port_in;
      end
   end

endmodule

### rtl/core/uhcr_rsp_stage.sv
// Result register of the host controller register file.
`timescale 1ns / 1ps

module uhcr_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  uhcr_pkg::rsp_type rsp_in,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output uhcr_pkg::rsp_type rsp_ff
);
   import uhcr_pkg::*;

   logic valid_ff;
   logic valid_in;

   assign rsp_valid = valid_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### rtl/core/usb_host_controller_registers.sv
// Top level of the host controller register file.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   kind, addr, wdata, port, device_present
//   rsp      out        rsp_valid/rsp_stall   rdata, irq_raise, port_reset_req, reset_port
//
// One request per cycle while req_stall is low; each accepted request gives one response
// (input register, then register update and result register).
// Synchronous reset loads the register defaults.
// A stalled response holds its register; the input register then holds too and
// req_stall rises while it is full.
`timescale 1ns / 1ps

module usb_host_controller_registers (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_addr,
   input  logic [31:0] req_wdata,
   input  logic        req_port,
   input  logic        req_device_present,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_rdata,
   output logic        rsp_irq_raise,
   output logic        rsp_port_reset_req,
   output logic        rsp_reset_port
);
   import uhcr_pkg::*;

   `include "usb_host_controller_registers_defines.svh"

   req_type    req_in;
   req_type    req_ff;
   logic       in_valid_ff;
   logic       advance;
   rsp_type    rsp_in;
   rsp_type    rsp_ff;
   status_type status;

   assign req_in.kind           = req_kind;
   assign req_in.addr           = req_addr;
   assign req_in.wdata          = req_wdata;
   assign req_in.port           = req_port;
   assign req_in.device_present = req_device_present;

   // move the held request into the result register when that register frees up
   assign advance = in_valid_ff && (!rsp_valid || !rsp_stall);

   uhcr_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in    (req_in),
      .advance   (advance),
      .valid_ff  (in_valid_ff),
      .req_ff    (req_ff)
   );

   uhcr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .rsp_in  (rsp_in),
      .status  (status)
   );

   uhcr_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .rsp_in    (rsp_in),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_ff    (rsp_ff)
   );

   assign rsp_rdata          = rsp_ff.rdata;
   assign rsp_irq_raise      = rsp_ff.irq_raise;
   assign rsp_port_reset_req = rsp_ff.port_reset_req;
   assign rsp_reset_port     = rsp_ff.reset_port;

   `UHCR_ASSERT_NOW(a_irq_tracks_state, rsp_valid, rsp_irq_raise == status.irq_level, "irq level out of step with held response")
   `UHCR_ASSERT_NOW(a_port_reset_sets_rhsc, rsp_valid && rsp_port_reset_req, status.rhsc, "port reset without root hub status change")
   `UHCR_ASSERT_NOW(a_reset_port_zero, rsp_valid && !rsp_port_reset_req, !rsp_reset_port, "reset port index set without port reset")
   `UHCR_ASSERT_NEXT(a_full_stall_holds, in_valid_ff && rsp_valid && rsp_stall, in_valid_ff, "held request dropped while response stalled")

endmodule
